// File: rtl/pll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pll_pkg;

	localparam int VW = 20;
	localparam int SW = 8;
	localparam int STW = 3;

	typedef logic [VW-1:0]  vol_t;
	typedef logic [1:0]     dir_t;
	typedef logic [STW-1:0] status_t;

	localparam vol_t VMAX = {VW{1'b1}};

	localparam status_t ST_PARTIAL = 3'd0;
	localparam status_t ST_DONE    = 3'd1;
	localparam status_t ST_CANCEL  = 3'd2;
	localparam status_t ST_REJECT  = 3'd3;

	localparam dir_t DIR_OPEN_BUY   = 2'd0;
	localparam dir_t DIR_OPEN_SELL  = 2'd1;
	localparam dir_t DIR_CLOSE_BUY  = 2'd2;
	localparam dir_t DIR_CLOSE_SELL = 2'd3;

	localparam logic REG_MAX_POSITION = 1'b0;
	localparam logic REG_BYPASS_LIMIT = 1'b1;

	typedef struct packed {
		logic          kind;
		logic          open_close;
		logic          side;
		vol_t          volume;
		logic [SW-1:0] slot;
		status_t       report_status;
		logic          pending_cancel;
	} item_t;

	typedef struct packed {
		vol_t          short_position;
		vol_t          long_position;
		vol_t          filled_total;
		vol_t          killed_volume;
		status_t       status_out;
		logic [SW-1:0] slot_out;
		logic          deferred;
		vol_t          granted_volume;
	} res_t;

	typedef struct packed {
		logic load_in;
		logic rd_en;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

// File: rtl/pll_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pll_ctrl
	import pll_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  wire  m_tready,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd.load_in = 1'b0;
		cmd.rd_en   = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/pll_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pll_dp
	import pll_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_wen,
	input  wire        cfg_index,
	input  wire  [VW-1:0] cfg_wdata,
	input  wire  cmd_t  cmd,
	input  wire  item_t item,
	output res_t       res
);

	localparam int DEPTH = (SLOTS < 256) ? SLOTS : 256;
	localparam int IW    = $clog2(DEPTH);
	localparam int MW    = 2 + 2 * VW;

	function automatic vol_t sat_add(input vol_t a, input vol_t b);
		logic [VW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[VW] ? VMAX : s[VW-1:0];
	endfunction

	function automatic vol_t sat_sub(input vol_t a, input vol_t b);
		return (a > b) ? (a - b) : '0;
	endfunction

	vol_t          max_pos_q;
	logic          bypass_q;
	vol_t          long_q;
	vol_t          short_q;
	vol_t          bucket_q [4];
	logic [IW-1:0] next_q;
	item_t         item_q;
	logic [IW-1:0] idx_q;
	logic [MW-1:0] mem [DEPTH];
	logic [MW-1:0] rd_q;

	logic [31:0]   rem;
	logic [IW-1:0] idx_d;

	always_comb begin
		rem = 32'(item_q.slot);
		for (int k = 7; k >= 0; k--) begin
			if (rem >= (32'(SLOTS) << k)) begin
				rem = rem - (32'(SLOTS) << k);
			end
		end
		idx_d = rem[IW-1:0];
	end

	vol_t m_order;
	vol_t m_filled;
	dir_t m_dir;
	assign m_order  = rd_q[VW-1:0];
	assign m_filled = rd_q[2*VW-1:VW];
	assign m_dir    = rd_q[MW-1:2*VW];

	dir_t dir_in;
	assign dir_in = {item_q.open_close, item_q.side};

	logic signed [VW+2:0] m_s, l_s, s_s, h;
	vol_t                 hr;
	vol_t                 granted;
	logic                 deferred;

	always_comb begin
		m_s = $signed({3'b000, max_pos_q});
		l_s = $signed({3'b000, long_q});
		s_s = $signed({3'b000, short_q});
		case (dir_in)
			DIR_OPEN_BUY:  h = m_s - l_s + s_s;
			DIR_OPEN_SELL: h = m_s - s_s + l_s;
			DIR_CLOSE_BUY: begin
				h = m_s + s_s - l_s;
				if (h > s_s) h = s_s;
			end
			default: begin
				h = m_s + l_s - s_s;
				if (h > l_s) h = l_s;
			end
		endcase
		if (h < 0) begin
			hr = '0;
		end else if (h > $signed({3'b000, VMAX})) begin
			hr = VMAX;
		end else begin
			hr = h[VW-1:0];
		end
		deferred = (bucket_q[dir_in] != '0);
		if (deferred) begin
			granted = '0;
		end else if (bypass_q) begin
			granted = item_q.volume;
		end else begin
			granted = (hr > item_q.volume) ? item_q.volume : hr;
		end
	end

	vol_t    nfilled;
	vol_t    nlong;
	vol_t    nshort;
	vol_t    nbucket;
	status_t nstatus;
	vol_t    killed;
	logic    release_b;

	always_comb begin
		nfilled = sat_add(m_filled, item_q.volume);
		nlong   = long_q;
		nshort  = short_q;
		case (m_dir)
			DIR_OPEN_BUY:  nlong  = sat_add(long_q, item_q.volume);
			DIR_OPEN_SELL: nshort = sat_add(short_q, item_q.volume);
			DIR_CLOSE_BUY: nshort = sat_sub(short_q, item_q.volume);
			default:       nlong  = sat_sub(long_q, item_q.volume);
		endcase
		nstatus = item_q.report_status;
		if (nstatus == ST_PARTIAL && nfilled == m_order) nstatus = ST_DONE;
		killed    = (nstatus == ST_CANCEL) ? sat_sub(m_order, nfilled) : '0;
		release_b = !item_q.pending_cancel &&
			(nstatus == ST_DONE || nstatus == ST_CANCEL || nstatus == ST_REJECT);
		nbucket   = release_b ? '0 : sat_sub(bucket_q[m_dir], item_q.volume);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pos_q <= '0;
			bypass_q  <= 1'b0;
			long_q    <= '0;
			short_q   <= '0;
			next_q    <= '0;
			for (int i = 0; i < 4; i++) bucket_q[i] <= '0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_MAX_POSITION: max_pos_q <= cfg_wdata;
					REG_BYPASS_LIMIT: bypass_q  <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				if (item_q.kind) begin
					long_q          <= nlong;
					short_q         <= nshort;
					bucket_q[m_dir] <= nbucket;
				end else if (!deferred) begin
					bucket_q[dir_in] <= granted;
					next_q <= (next_q == IW'(DEPTH - 1)) ? '0 : next_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) item_q <= item;
		if (cmd.rd_en) begin
			idx_q <= idx_d;
			rd_q  <= mem[idx_d];
		end
		if (cmd.exec) begin
			if (item_q.kind) begin
				mem[idx_q] <= {m_dir, nfilled, m_order};
			end else if (!deferred) begin
				mem[next_q] <= {dir_in, {VW{1'b0}}, granted};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (item_q.kind) begin
				res.granted_volume <= '0;
				res.deferred       <= 1'b0;
				res.slot_out       <= item_q.slot;
				res.status_out     <= nstatus;
				res.killed_volume  <= killed;
				res.filled_total   <= nfilled;
				res.long_position  <= nlong;
				res.short_position <= nshort;
			end else begin
				res.granted_volume <= granted;
				res.deferred       <= deferred;
				res.slot_out       <= deferred ? '0 : SW'(next_q);
				res.status_out     <= ST_PARTIAL;
				res.killed_volume  <= '0;
				res.filled_total   <= '0;
				res.long_position  <= long_q;
				res.short_position <= short_q;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/position_limit_ledger.sv
// Position limit ledger for one contract.
// Input channel s_*: one item per order request or execution report.
//   s_tuser is kind (0 order, 1 report); s_tdata carries the other fields.
// Output channel m_*: exactly one result item per input item, in order.
// Config port: cfg_wen/cfg_index/cfg_wdata write max_position (0) and
//   bypass_limit (1); write only while no item is in flight.
// Each item goes through accept, slot memory read, and update with result
//   load, in that order. The slot memory read is registered, and a new item
//   is accepted only once the last one has been updated. The result is
//   presented on m_* from the output register after the update step.
// A finished result waits in the output register; the next item is still
//   accepted and read, and its update waits until the result is taken.
// Reset clears holdings, frozen buckets, the slot pointer and the config
//   registers; the slot memory is not cleared and a report for a slot no
//   order has used returns undefined slot data.
`timescale 1ns / 1ps
`default_nettype none

module position_limit_ledger
	import pll_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// open_close, side, volume[20], slot[8], report_status[3], pending_cancel, zero pad
	input  wire  [39:0]  s_tdata,
	// kind
	input  wire          s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// granted_volume[20], deferred, slot_out[8], status_out[3], killed_volume[20],
	// filled_total[20], long_position[20], short_position[20]
	output logic [111:0] m_tdata,
	input  wire          cfg_wen,
	input  wire          cfg_index,
	input  wire  [19:0]  cfg_wdata
);

	cmd_t  cmd;
	item_t item;
	res_t  res;

	assign item.kind           = s_tuser;
	assign item.open_close     = s_tdata[0];
	assign item.side           = s_tdata[1];
	assign item.volume         = s_tdata[21:2];
	assign item.slot           = s_tdata[29:22];
	assign item.report_status  = s_tdata[32:30];
	assign item.pending_cancel = s_tdata[33];

	assign m_tdata = res;

	pll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	pll_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.item      (item),
		.res       (res)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!m_tvalid || m_tready))
		else $error("result overwritten before it was taken");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while one is in flight");

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> m_tvalid)
		else $error("update did not present a result");

	a_deferred_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[20]) |-> (m_tdata[19:0] == 20'd0))
		else $error("deferred order shows a nonzero grant");

endmodule

`default_nettype wire

// File: dv/position_limit_ledger_test.sv
`timescale 1ns / 1ps

module position_limit_ledger_test;
	import pll_pkg::*;

	localparam logic    KIND_ORDER  = 1'b0;
	localparam logic    KIND_REPORT = 1'b1;
	localparam status_t ST_OTHER    = 3'd4;
	localparam status_t ST_TOP      = 3'd7;
	localparam int      QUIET_LIMIT = 1000;
	localparam int      SHOW_LIMIT  = 10;

	typedef struct {
		logic  is_cfg;
		logic  reg_idx;
		vol_t  reg_val;
		item_t it;
		logic  typed;
		res_t  res;
	} row_t;

	logic         clk;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata   = '0;
	logic         s_tuser   = 1'b0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [111:0] m_tdata;
	logic         cfg_wen   = 1'b0;
	logic         cfg_index = 1'b0;
	logic [19:0]  cfg_wdata = '0;

	// ledger shadow
	vol_t       max_pos_q;
	logic       bypass_q;
	vol_t       long_q, short_q;
	vol_t       frozen_q [4];
	logic [7:0] slot_ptr;
	vol_t       ord_vol_q [256];
	vol_t       fill_q [256];
	dir_t       dir_q [256];
	bit         used_q [256];
	logic [7:0] last_slot_of_dir [4];
	logic [7:0] last_taken;

	res_t ledger_rows_due [$];
	res_t last_row;
	res_t due_row, seen_row;
	row_t opening_rows [$];

	int  items_in = 0;
	int  rows_out = 0;
	int  deferrals = 0;
	int  slots_taken = 0;
	int  bad_rows = 0;
	int  quiet = 0;
	bit  calm = 1'b0;

	position_limit_ledger u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic vol_t sat_add(input vol_t a, input vol_t b);
		logic [VW:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[VW] ? VMAX : t[VW-1:0];
	endfunction

	function automatic vol_t sat_sub(input vol_t a, input vol_t b);
		return (a > b) ? a - b : '0;
	endfunction

	function automatic res_t book_item(input item_t it);
		res_t       r;
		dir_t       d;
		logic [7:0] idx;
		longint     m, l, s, h;
		r = '0;
		if (it.kind == KIND_ORDER) begin
			d = {it.open_close, it.side};
			if (frozen_q[d] != '0) begin
				r.deferred = 1'b1;
			end else begin
				idx = slot_ptr;
				if (bypass_q) begin
					r.granted_volume = it.volume;
				end else begin
					m = longint'(max_pos_q);
					l = longint'(long_q);
					s = longint'(short_q);
					case (d)
						DIR_OPEN_BUY:  h = m - l + s;
						DIR_OPEN_SELL: h = m - s + l;
						DIR_CLOSE_BUY: begin
							h = m + s - l;
							if (h > s) h = s;
						end
						default: begin
							h = m + l - s;
							if (h > l) h = l;
						end
					endcase
					if (h < 0) h = 0;
					if (h > longint'(VMAX)) h = longint'(VMAX);
					r.granted_volume = (h < longint'(it.volume)) ? vol_t'(h) : it.volume;
				end
				frozen_q[d] = r.granted_volume;
				ord_vol_q[idx] = r.granted_volume;
				fill_q[idx] = '0;
				dir_q[idx] = d;
				used_q[idx] = 1'b1;
				last_slot_of_dir[d] = idx;
				last_taken = idx;
				r.slot_out = idx;
				slot_ptr = idx + 8'd1;
				slots_taken++;
			end
		end else begin
			idx = it.slot;
			d = dir_q[idx];
			r.status_out = it.report_status;
			if (it.volume != '0) begin
				fill_q[idx] = sat_add(fill_q[idx], it.volume);
				case (d)
					DIR_OPEN_BUY:  long_q  = sat_add(long_q, it.volume);
					DIR_OPEN_SELL: short_q = sat_add(short_q, it.volume);
					DIR_CLOSE_BUY: short_q = sat_sub(short_q, it.volume);
					default:       long_q  = sat_sub(long_q, it.volume);
				endcase
				frozen_q[d] = sat_sub(frozen_q[d], it.volume);
			end
			r.filled_total = fill_q[idx];
			if (r.status_out == ST_PARTIAL && fill_q[idx] == ord_vol_q[idx])
				r.status_out = ST_DONE;
			if (r.status_out == ST_CANCEL)
				r.killed_volume = sat_sub(ord_vol_q[idx], fill_q[idx]);
			if (!it.pending_cancel && (r.status_out == ST_DONE || r.status_out == ST_CANCEL
					|| r.status_out == ST_REJECT))
				frozen_q[d] = '0;
			r.slot_out = it.slot;
		end
		r.long_position = long_q;
		r.short_position = short_q;
		return r;
	endfunction

	function automatic row_t mk_order(input dir_t d, input vol_t vol);
		row_t r;
		r = '{default: '0};
		r.it = '0;
		r.res = '0;
		r.it.kind = KIND_ORDER;
		r.it.open_close = d[1];
		r.it.side = d[0];
		r.it.volume = vol;
		return r;
	endfunction

	function automatic row_t mk_report(input logic [7:0] slot, input vol_t vol,
			input status_t st, input logic pc);
		row_t r;
		r = '{default: '0};
		r.it = '0;
		r.res = '0;
		r.it.kind = KIND_REPORT;
		r.it.slot = slot;
		r.it.volume = vol;
		r.it.report_status = st;
		r.it.pending_cancel = pc;
		return r;
	endfunction

	function automatic row_t mk_write(input logic idx, input vol_t val);
		row_t r;
		r = '{default: '0};
		r.it = '0;
		r.res = '0;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic row_t pin(input row_t r, input vol_t granted, input logic deferred,
			input logic [7:0] slot, input status_t st, input vol_t filled, input vol_t lng);
		r.typed = 1'b1;
		r.res = '0;
		r.res.granted_volume = granted;
		r.res.deferred = deferred;
		r.res.slot_out = slot;
		r.res.status_out = st;
		r.res.filled_total = filled;
		r.res.long_position = lng;
		return r;
	endfunction

	function automatic logic [7:0] any_used_slot();
		logic [7:0] c;
		for (int k = 0; k < 64; k++) begin
			c = 8'($urandom_range(0, 255));
			if (used_q[c]) return c;
		end
		return last_taken;
	endfunction

	function automatic vol_t pick_vol();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10) return '0;
		if (p < 80) return vol_t'($urandom_range(1, 2000));
		return vol_t'($urandom_range(0, VMAX));
	endfunction

	task automatic settle();
		s_tvalid <= 1'b0;
		while (ledger_rows_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_row(input row_t r);
		res_t pred;
		if (r.is_cfg) begin
			settle();
			cfg_index <= r.reg_idx;
			cfg_wdata <= r.reg_val;
			cfg_wen <= 1'b1;
			@(posedge clk);
			cfg_wen <= 1'b0;
			if (r.reg_idx == REG_MAX_POSITION)
				max_pos_q = r.reg_val;
			else
				bypass_q = r.reg_val[0];
			@(posedge clk);
		end else begin
			s_tuser <= r.it.kind;
			s_tdata <= {6'd0, r.it.pending_cancel, r.it.report_status, r.it.slot,
				r.it.volume, r.it.side, r.it.open_close};
			s_tvalid <= 1'b1;
			do @(posedge clk); while (!s_tready);
			pred = book_item(r.it);
			last_row = pred;
			ledger_rows_due.push_back(r.typed ? r.res : pred);
			items_in++;
			if (pred.deferred) deferrals++;
			if (!calm && $urandom_range(0, 99) < 18) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// order followed by up to two fills and, in most cases, a last report
	task automatic run_trade();
		dir_t       d;
		logic [7:0] s;
		vol_t       left, f;
		int         n;
		d = dir_t'($urandom_range(0, 3));
		push_row(mk_order(d, pick_vol()));
		if (last_row.deferred) return;
		s = last_row.slot_out;
		left = last_row.granted_volume;
		n = $urandom_range(0, 2);
		repeat (n) begin
			f = vol_t'($urandom_range(0, left));
			push_row(mk_report(s, f, ST_PARTIAL, 1'b0));
			left = left - f;
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3: push_row(mk_report(s, left, ST_DONE, $urandom_range(0, 4) == 0));
			4, 5: push_row(mk_report(s, left, ST_PARTIAL, 1'b0));
			6: push_row(mk_report(s, vol_t'($urandom_range(0, left)), ST_CANCEL,
				$urandom_range(0, 3) == 0));
			7: push_row(mk_report(s, '0, ST_REJECT, 1'b0));
			8: push_row(mk_report(s, vol_t'($urandom_range(0, left)),
				status_t'($urandom_range(ST_OTHER, ST_TOP)), 1'($urandom_range(0, 1))));
			default: ;
		endcase
	endtask

	task automatic run_mix(input int count);
		int start;
		int p;
		start = items_in;
		while (items_in - start < count) begin
			p = $urandom_range(0, 99);
			if (p < 65)
				run_trade();
			else if (p < 85)
				push_row(mk_report(any_used_slot(), pick_vol(),
					status_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
			else
				push_row(mk_order(dir_t'($urandom_range(0, 3)), pick_vol()));
		end
	endtask

	// output side: random back-pressure and in-order compare
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			rows_out++;
			seen_row = res_t'(m_tdata);
			if (ledger_rows_due.size() == 0) begin
				bad_rows++;
				if (bad_rows <= SHOW_LIMIT)
					$display("result %0d arrived with nothing outstanding: %h",
						rows_out, m_tdata);
			end else begin
				due_row = ledger_rows_due.pop_front();
				if (seen_row.granted_volume !== due_row.granted_volume
						|| seen_row.deferred !== due_row.deferred
						|| seen_row.slot_out !== due_row.slot_out
						|| seen_row.status_out !== due_row.status_out
						|| seen_row.killed_volume !== due_row.killed_volume
						|| seen_row.filled_total !== due_row.filled_total
						|| seen_row.long_position !== due_row.long_position
						|| seen_row.short_position !== due_row.short_position) begin
					bad_rows++;
					if (bad_rows <= SHOW_LIMIT) begin
						$write("result %0d exp: grant=%0d def=%0d slot=%0d st=%0d ",
							rows_out, due_row.granted_volume, due_row.deferred,
							due_row.slot_out, due_row.status_out);
						$display("kill=%0d fill=%0d long=%0d short=%0d",
							due_row.killed_volume, due_row.filled_total,
							due_row.long_position, due_row.short_position);
						$write("result %0d got: grant=%0d def=%0d slot=%0d st=%0d ",
							rows_out, seen_row.granted_volume, seen_row.deferred,
							seen_row.slot_out, seen_row.status_out);
						$display("kill=%0d fill=%0d long=%0d short=%0d",
							seen_row.killed_volume, seen_row.filled_total,
							seen_row.long_position, seen_row.short_position);
					end
				end
			end
		end
		m_tready <= calm || ($urandom_range(0, 99) >= 18);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet = quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("no traffic for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, ledger_rows_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		max_pos_q = '0;
		bypass_q = 1'b0;
		long_q = '0;
		short_q = '0;
		slot_ptr = '0;
		last_taken = '0;
		for (int k = 0; k < 4; k++) begin
			frozen_q[k] = '0;
			last_slot_of_dir[k] = '0;
		end
		for (int k = 0; k < 256; k++) begin
			ord_vol_q[k] = '0;
			fill_q[k] = '0;
			dir_q[k] = DIR_OPEN_BUY;
			used_q[k] = 1'b0;
		end

		opening_rows.push_back(pin(mk_order(DIR_OPEN_BUY, 20'd5), '0, 1'b0, 8'd0,
			ST_PARTIAL, '0, '0));
		opening_rows.push_back(pin(mk_report(8'd0, '0, ST_PARTIAL, 1'b0), '0, 1'b0, 8'd0,
			ST_DONE, '0, '0));
		opening_rows.push_back(mk_write(REG_MAX_POSITION, VMAX));
		opening_rows.push_back(pin(mk_order(DIR_OPEN_BUY, VMAX), VMAX, 1'b0, 8'd1,
			ST_PARTIAL, '0, '0));
		opening_rows.push_back(pin(mk_order(DIR_OPEN_BUY, 20'd1), '0, 1'b1, 8'd0,
			ST_PARTIAL, '0, '0));
		opening_rows.push_back(pin(mk_report(8'd1, VMAX, ST_PARTIAL, 1'b0), '0, 1'b0, 8'd1,
			ST_DONE, VMAX, VMAX));
		opening_rows.push_back(pin(mk_order(DIR_CLOSE_SELL, VMAX), VMAX, 1'b0, 8'd2,
			ST_PARTIAL, '0, VMAX));
		opening_rows.push_back(mk_report(8'd2, 20'd100, ST_PARTIAL, 1'b0));
		opening_rows.push_back(mk_report(8'd2, '0, ST_CANCEL, 1'b1));
		opening_rows.push_back(mk_order(DIR_CLOSE_SELL, 20'd5));
		opening_rows.push_back(mk_report(8'd2, '0, ST_REJECT, 1'b0));
		opening_rows.push_back(mk_report(8'd2, VMAX, ST_OTHER, 1'b0));
		opening_rows.push_back(mk_order(DIR_OPEN_SELL, 20'd300));
		opening_rows.push_back(mk_report(8'd3, 20'd300, ST_DONE, 1'b1));
		opening_rows.push_back(mk_order(DIR_CLOSE_BUY, 20'd1000));
		opening_rows.push_back(mk_report(8'd4, 20'd50, ST_CANCEL, 1'b0));
		opening_rows.push_back(mk_write(REG_MAX_POSITION, '0));
		opening_rows.push_back(mk_order(DIR_OPEN_BUY, 20'd10));
		opening_rows.push_back(mk_order(DIR_OPEN_SELL, 20'd10));
		opening_rows.push_back(mk_write(REG_BYPASS_LIMIT, 20'd1));
		opening_rows.push_back(mk_order(DIR_OPEN_SELL, 20'd777));
		opening_rows.push_back(mk_order(DIR_OPEN_SELL, 20'd1));
		opening_rows.push_back(mk_report(8'd7, 20'd777, ST_TOP, 1'b0));
		opening_rows.push_back(mk_report(8'd5, 20'd3, ST_PARTIAL, 1'b0));
		opening_rows.push_back(mk_report(8'd5, '0, ST_REJECT, 1'b0));
		opening_rows.push_back(mk_write(REG_BYPASS_LIMIT, '0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_rows[i])
			push_row(opening_rows[i]);

		push_row(mk_write(REG_MAX_POSITION, vol_t'($urandom_range(0, 5000))));
		run_mix(60);

		push_row(mk_write(REG_MAX_POSITION, VMAX));
		calm = 1'b1;
		run_mix(60);
		settle();
		calm = 1'b0;

		// release every frozen bucket, then run the slot ring past its end
		push_row(mk_write(REG_MAX_POSITION, '0));
		push_row(mk_write(REG_BYPASS_LIMIT, 20'd1));
		for (int k = 0; k < 4; k++)
			if (frozen_q[k] != '0 && dir_q[last_slot_of_dir[k]] == dir_t'(k))
				push_row(mk_report(last_slot_of_dir[k], '0, ST_REJECT, 1'b0));
		while (slots_taken < 270)
			push_row(mk_order(dir_t'($urandom_range(0, 3)), '0));
		run_mix(60);

		push_row(mk_write(REG_MAX_POSITION, vol_t'($urandom_range(0, VMAX))));
		push_row(mk_write(REG_BYPASS_LIMIT, '0));
		run_mix(60);

		settle();
		repeat (8) @(posedge clk);

		$display("%0d items sent (%0d held back on a frozen bucket), %0d results compared",
			items_in, deferrals, rows_out);
		$display("%0d slots handed out past the ring wrap, limits zero to full, bypass on/off",
			slots_taken);
		if (bad_rows == 0 && ledger_rows_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d bad results, %0d still outstanding", bad_rows,
				ledger_rows_due.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
